// ===== hdl/trsd_pkg.sv =====
package trsd_pkg;

  // Default number of header bytes skipped when a frame opens with the header mark.
  localparam int unsigned HeaderBytesDefault = 11;

  // Field widths.
  localparam int unsigned ByteW    = 8;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned LitCntW  = 7;
  localparam int unsigned HdrCntW  = 4;
  localparam int unsigned PalDepth = 256;
  localparam int unsigned PalAddrW = 8;

  // Packed stream widths.
  localparam int unsigned InDataW  = 40;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;

  // Byte codes of the frame stream.
  localparam logic [ByteW-1:0] HeaderMark = 8'd10;
  localparam logic [ByteW-1:0] LiteralMax = 8'd127;

  // Operation codes carried in the input tuser.
  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_PAL_LOAD = 1'b1
  } op_e;

  // Transparent run color (magenta).
  localparam logic [ColorW-1:0] TranspColor = 24'hFF00FF;

  // Decision of the control unit for one accepted byte.
  typedef struct packed {
    logic              emit;
    logic              transp;
    logic [ByteW-1:0]  run_len;
  } ctrl_res_t;

endpackage

// ===== hdl/trsd_pal_mem.sv =====
module trsd_pal_mem (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [trsd_pkg::PalAddrW-1:0] wr_addr_i,
  input  logic [trsd_pkg::ColorW-1:0]   wr_data_i,
  input  logic                          rd_en_i,
  input  logic [trsd_pkg::PalAddrW-1:0] rd_addr_i,
  output logic [trsd_pkg::ColorW-1:0]   rd_data_o
);
  import trsd_pkg::*;

  logic [ColorW-1:0] mem_q [PalDepth];
  logic [ColorW-1:0] rd_data_q;

  // Palette write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/trsd_ctrl.sv =====
module trsd_ctrl #(
  parameter int unsigned HEADER_BYTES = trsd_pkg::HeaderBytesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_wdata_i,
  input  logic                       accept_i,
  input  trsd_pkg::op_e              op_i,
  input  logic                       frame_start_i,
  input  logic [trsd_pkg::ByteW-1:0] data_byte_i,
  output trsd_pkg::ctrl_res_t        res_o
);
  import trsd_pkg::*;

  logic               hdr_en_q, hdr_en_d;
  logic [LitCntW-1:0] lit_left_q, lit_left_d;
  logic [HdrCntW-1:0] hdr_left_q, hdr_left_d;

  // Header enable register.
  always_comb begin
    hdr_en_d = hdr_en_q;
    if (cfg_we_i) begin
      hdr_en_d = cfg_wdata_i;
    end
  end

  // Byte decision: header skip, literal pixel or new command.
  always_comb begin
    logic take_cmd;
    take_cmd   = 1'b0;
    lit_left_d = lit_left_q;
    hdr_left_d = hdr_left_q;
    res_o      = '0;
    if (accept_i && op_i == OP_DECODE) begin
      if (frame_start_i) begin
        lit_left_d = '0;
        hdr_left_d = '0;
        if (hdr_en_q && data_byte_i == HeaderMark) begin
          hdr_left_d = HdrCntW'(HEADER_BYTES - 1);
        end else begin
          take_cmd = 1'b1;
        end
      end else if (hdr_left_q != '0) begin
        hdr_left_d = hdr_left_q - HdrCntW'(1);
      end else if (lit_left_q != '0) begin
        lit_left_d    = lit_left_q - LitCntW'(1);
        res_o.emit    = 1'b1;
        res_o.transp  = 1'b0;
        res_o.run_len = ByteW'(1);
      end else begin
        take_cmd = 1'b1;
      end

      if (take_cmd) begin
        if (data_byte_i <= LiteralMax) begin
          lit_left_d = data_byte_i[LitCntW-1:0];
        end else begin
          res_o.emit    = 1'b1;
          res_o.transp  = 1'b1;
          res_o.run_len = ByteW'(9'd256 - {1'b0, data_byte_i});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_en_q   <= 1'b1;
      lit_left_q <= '0;
      hdr_left_q <= '0;
    end else begin
      hdr_en_q   <= hdr_en_d;
      lit_left_q <= lit_left_d;
      hdr_left_q <= hdr_left_d;
    end
  end

endmodule

// ===== hdl/transparent_rle_sprite_decoder.sv =====
// A pixel result passes the read stage and then the output register before it reaches the master side.
// Throughput: one byte or palette load per cycle while the master side does not stall.
// The palette memory is addressed in the accept cycle and its read data is registered with the read stage.
// Reset clears the literal and header counters, sets header enable, and empties the pipeline.
// Palette contents are not cleared by reset and are valid only once loaded.
module transparent_rle_sprite_decoder #(
  parameter int unsigned HEADER_BYTES = trsd_pkg::HeaderBytesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration: header enable.
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  // Input stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: data_byte, palette_index, palette_red, palette_green, palette_blue
  input  logic [trsd_pkg::InDataW-1:0]  s_axis_tdata,
  // tuser: operation, frame_start
  input  logic [trsd_pkg::InUserW-1:0]  s_axis_tuser,
  // Output stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: pixel_red, pixel_green, pixel_blue, run_length
  output logic [trsd_pkg::OutDataW-1:0] m_axis_tdata,
  // tuser: is_transparent
  output logic                          m_axis_tuser
);
  import trsd_pkg::*;

  logic              accept;
  op_e               op;
  ctrl_res_t         res;
  logic [ColorW-1:0] pal_rdata;
  logic              s1_adv;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_transp_q;
  logic [ByteW-1:0]  s1_len_q;
  logic              m_valid_q, m_valid_d;
  logic [OutDataW-1:0] m_data_q;
  logic              m_user_q;

  // Handshake: the read stage moves on when the output register is free.
  assign s1_adv        = !m_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op            = op_e'(s_axis_tuser[0]);

  trsd_ctrl #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .op_i         (op),
    .frame_start_i(s_axis_tuser[1]),
    .data_byte_i  (s_axis_tdata[7:0]),
    .res_o        (res)
  );

  // Palette memory: loads write it, every accepted byte reads it.
  trsd_pal_mem u_pal_mem (
    .clk_i    (clk_i),
    .wr_en_i  (accept && op == OP_PAL_LOAD),
    .wr_addr_i(s_axis_tdata[15:8]),
    .wr_data_i({s_axis_tdata[23:16], s_axis_tdata[31:24], s_axis_tdata[39:32]}),
    .rd_en_i  (accept),
    .rd_addr_i(s_axis_tdata[7:0]),
    .rd_data_o(pal_rdata)
  );

  // Valid flags of the read stage and the output register.
  always_comb begin
    s1_valid_d = s1_valid_q;
    m_valid_d  = m_valid_q;
    if (s_axis_tready) begin
      s1_valid_d = accept && res.emit;
    end
    if (s1_adv) begin
      m_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      m_valid_q  <= m_valid_d;
    end
  end

  // Read stage payload, captured together with the palette read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_transp_q <= res.transp;
      s1_len_q    <= res.run_len;
    end
  end

  // Output register: transparent runs take magenta, literals the palette color.
  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      if (s1_transp_q) begin
        m_data_q <= {s1_len_q, TranspColor[7:0], TranspColor[15:8], TranspColor[23:16]};
      end else begin
        m_data_q <= {s1_len_q, pal_rdata[7:0], pal_rdata[15:8], pal_rdata[23:16]};
      end
      m_user_q <= s1_transp_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
